[hw/rtl/ssrc_pkg.sv]
package ssrc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CODES_DEF     = 4;
    localparam int SPEED_DEFAULT_DEF = 100;
    localparam int SPEED_MIN_DEF     = 10;
    localparam int SPEED_MAX_DEF     = 400;

    localparam int INT16_MAX = 32767;

    localparam int TYPE_W    = 8;
    localparam int CODE_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int NARROW_W  = 16;
    localparam int DVS_W     = 16;
    localparam int CNT_USE_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W = TYPE_W + CODE_W + VALUE_W;

    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [TYPE_W-1:0]    MATCH_TYPE_RST = 8'd2;
    localparam logic [CNT_USE_W-1:0] CODES_USE_RST  = 3'd1;
    localparam logic [NARROW_W-1:0]  MULT_RST       = 16'd1;
    localparam logic [DVS_W-1:0]     BASE_DIV_RST   = 16'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_TYPE = 3'd0,
        CFG_CODE_LIST  = 3'd1,
        CFG_CODES_USE  = 3'd2,
        CFG_MULTIPLIER = 3'd3,
        CFG_BASE_DIV   = 3'd4,
        CFG_SPEED      = 3'd5,
        CFG_CARRY_EN   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_SPEED,
        ST_DIV_VALUE,
        ST_SEND
    } t_back_state;

    // One queued word: scaled items carry the wrapped 16-bit product in the low bits.
    typedef struct packed {
        logic               scaled;
        logic [VALUE_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [TYPE_W-1:0]    match_type;
        logic [CNT_USE_W-1:0] codes_in_use;
        logic [NARROW_W-1:0]  multiplier;
    } t_front_cfg;

    typedef struct packed {
        logic [DVS_W-1:0] base_divisor;
        logic [DVS_W-1:0] speed_percent;
        logic             carry_en;
    } t_back_cfg;

endpackage

[hw/rtl/ssrc_front.sv]
module ssrc_front #(
    parameter int P_MAX_CODES = ssrc_pkg::MAX_CODES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [ssrc_pkg::IN_DATA_W-1:0]         i_data,
    output logic                                   o_ready,
    input  ssrc_pkg::t_front_cfg                   i_cfg,
    input  logic [P_MAX_CODES-1:0][ssrc_pkg::CODE_W-1:0] i_codes,
    input  logic                                   i_q_full,
    output logic                                   o_push,
    output ssrc_pkg::t_item                        o_item
);

    logic [ssrc_pkg::TYPE_W-1:0]  w_type;
    logic [ssrc_pkg::CODE_W-1:0]  w_code;
    logic [ssrc_pkg::VALUE_W-1:0] w_value;
    logic [ssrc_pkg::VALUE_W-1:0] w_prod;
    logic                         w_code_hit;
    logic                         w_hit;

    assign w_type  = i_data[ssrc_pkg::TYPE_W-1:0];
    assign w_code  = i_data[ssrc_pkg::TYPE_W+ssrc_pkg::CODE_W-1:ssrc_pkg::TYPE_W];
    assign w_value = i_data[ssrc_pkg::IN_DATA_W-1:ssrc_pkg::TYPE_W+ssrc_pkg::CODE_W];

    always_comb begin
        w_code_hit = 1'b0;
        for (int i = 0; i < P_MAX_CODES; i++) begin
            if ((i < int'(i_cfg.codes_in_use)) && (i_codes[i] == w_code)) begin
                w_code_hit = 1'b1;
            end
        end
    end

    assign w_hit = w_code_hit && (w_type == i_cfg.match_type);

    // Only the low 16 bits of the product survive, so a 16x16 multiply is enough.
    assign w_prod = ssrc_pkg::VALUE_W'(w_value[ssrc_pkg::NARROW_W-1:0])
                  * ssrc_pkg::VALUE_W'(i_cfg.multiplier);

    assign o_ready       = !i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_item.scaled = w_hit;
    assign o_item.value  = w_hit ? {{(ssrc_pkg::VALUE_W-ssrc_pkg::NARROW_W){1'b0}},
                                    w_prod[ssrc_pkg::NARROW_W-1:0]}
                                 : w_value;

    // A push can only happen when the queue has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_ready)
        else $error("front pushed into a full queue");

endmodule

[hw/rtl/ssrc_queue.sv]
module ssrc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ssrc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ssrc_pkg::t_item o_head
);

    localparam int PTR_W = $clog2(ssrc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ssrc_pkg::QUEUE_DEPTH + 1);

    ssrc_pkg::t_item r_mem [ssrc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(ssrc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(ssrc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(ssrc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[hw/rtl/ssrc_divider.sv]
module ssrc_divider #(
    parameter int P_DVD_W = 23
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [P_DVD_W-1:0]         i_dividend,
    input  logic [ssrc_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [P_DVD_W-1:0]         o_quot,
    output logic [ssrc_pkg::DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(P_DVD_W + 1);
    localparam int DW    = ssrc_pkg::DVS_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [P_DVD_W-1:0] r_quot;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_fit;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign w_trial = {r_rem, r_quot[P_DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(P_DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[P_DVD_W-2:0], w_fit};
            r_rem  <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/ssrc_back.sv]
module ssrc_back #(
    parameter int P_DVD_W         = 23,
    parameter int P_SPEED_DEFAULT = ssrc_pkg::SPEED_DEFAULT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssrc_pkg::t_back_cfg          i_cfg,
    input  logic                         i_q_valid,
    input  ssrc_pkg::t_item              i_q_head,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssrc_pkg::VALUE_W-1:0] o_value,
    output logic                         o_scaled
);

    localparam int NW = ssrc_pkg::NARROW_W;
    localparam int MW = NW + 1;
    localparam int DW = ssrc_pkg::DVS_W;

    ssrc_pkg::t_back_state r_state;
    ssrc_pkg::t_back_state n_state;

    logic [NW-1:0]  r_rem;
    logic [NW-1:0]  r_sum;
    logic [MW-1:0]  r_res;
    logic           r_out_valid;
    logic [ssrc_pkg::VALUE_W-1:0] r_out_value;
    logic           r_out_scaled;

    logic               w_slot_free;
    logic               w_start;
    logic [P_DVD_W-1:0] w_dividend;
    logic [DW-1:0]      w_divisor;
    logic               w_div_done;
    logic [P_DVD_W-1:0] w_quot;
    logic [DW-1:0]      w_rem;
    logic [DW-1:0]      w_live_div;
    logic [MW-1:0]      w_sext;
    logic [MW-1:0]      w_mag;
    logic [NW-1:0]      w_sum;
    logic               w_load_pass;
    logic               w_load_res;

    ssrc_divider #(
        .P_DVD_W (P_DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_sum = i_q_head.value[NW-1:0] + (i_cfg.carry_en ? r_rem : '0);

    // Magnitude of the signed 16-bit sum; the most negative value needs the extra bit.
    assign w_sext = {r_sum[NW-1], r_sum};
    assign w_mag  = r_sum[NW-1] ? (MW'(0) - w_sext) : w_sext;

    always_comb begin
        if (w_quot == '0) begin
            w_live_div = DW'(1);
        end else if (w_quot > P_DVD_W'(ssrc_pkg::INT16_MAX)) begin
            w_live_div = DW'(ssrc_pkg::INT16_MAX);
        end else begin
            w_live_div = w_quot[DW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssrc_pkg::ST_IDLE: begin
                if (i_q_valid && i_q_head.scaled) begin
                    n_state = ssrc_pkg::ST_DIV_SPEED;
                end
            end
            ssrc_pkg::ST_DIV_SPEED: begin
                if (w_div_done) begin
                    n_state = ssrc_pkg::ST_DIV_VALUE;
                end
            end
            ssrc_pkg::ST_DIV_VALUE: begin
                if (w_div_done) begin
                    n_state = ssrc_pkg::ST_SEND;
                end
            end
            ssrc_pkg::ST_SEND: begin
                if (w_slot_free) begin
                    n_state = ssrc_pkg::ST_IDLE;
                end
            end
            default: n_state = ssrc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        w_start     = 1'b0;
        w_load_pass = 1'b0;
        w_load_res  = 1'b0;
        w_dividend  = P_DVD_W'(i_cfg.base_divisor) * P_DVD_W'(P_SPEED_DEFAULT);
        w_divisor   = (i_cfg.speed_percent == '0) ? DW'(1) : i_cfg.speed_percent;
        case (r_state)
            ssrc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.scaled) begin
                        o_q_pop = 1'b1;
                        w_start = 1'b1;
                    end else if (w_slot_free) begin
                        o_q_pop     = 1'b1;
                        w_load_pass = 1'b1;
                    end
                end
            end
            ssrc_pkg::ST_DIV_SPEED: begin
                if (w_div_done) begin
                    w_start    = 1'b1;
                    w_dividend = P_DVD_W'(w_mag);
                    w_divisor  = w_live_div;
                end
            end
            ssrc_pkg::ST_SEND: begin
                w_load_res = w_slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssrc_pkg::ST_IDLE;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Truncation toward zero leaves a remainder with the sign of the dividend.
            if (r_state == ssrc_pkg::ST_DIV_VALUE && w_div_done && i_cfg.carry_en) begin
                r_rem <= r_sum[NW-1] ? (NW'(0) - w_rem) : w_rem;
            end
            if (w_load_pass || w_load_res) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_head.scaled) begin
            r_sum <= w_sum;
        end
        if (r_state == ssrc_pkg::ST_DIV_VALUE && w_div_done) begin
            r_res <= r_sum[NW-1] ? (MW'(0) - w_quot[MW-1:0]) : w_quot[MW-1:0];
        end
        if (w_load_pass) begin
            r_out_value  <= i_q_head.value;
            r_out_scaled <= 1'b0;
        end else if (w_load_res) begin
            r_out_value  <= {{(ssrc_pkg::VALUE_W-MW){r_res[MW-1]}}, r_res};
            r_out_scaled <= 1'b1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_scaled = r_out_scaled;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ssrc_pkg::ST_DIV_SPEED
                        || r_state == ssrc_pkg::ST_DIV_VALUE))
        else $error("divider finished outside a divide state");

    a_live_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssrc_pkg::ST_DIV_SPEED && w_div_done)
        |-> (w_live_div != '0 && !w_live_div[DW-1]))
        else $error("live divisor outside 1..32767");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |=> !w_div_done)
        else $error("divider done held for more than one cycle");

    a_rem_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.carry_en |=> $stable(r_rem))
        else $error("remainder changed while carry is disabled");

endmodule

[hw/rtl/scroll_scaler_remainder_carry_core.sv]
// Event scaler with remainder carry.
//
// Input events arrive on the s_axis channel, one word per event, and each
// event gives exactly one result word on the m_axis channel, in order.
// Events whose type equals the configured type and whose code matches one
// of the active code entries are scaled: the value times the multiplier,
// wrapped to 16 bits, plus the carried remainder, divided toward zero by
// the live divisor base_divisor * SPEED_DEFAULT / speed_percent (clamped to
// 1..32767). m_axis_tuser is high for scaled results.
// A pass-through event is written into the queue and then into the output
// register before it reaches m_axis. A scaled event waits on the bit-serial
// divider, which runs twice per event, first for the live divisor and then
// for the value.
// A two-word queue sits between the classifier and the divider, so new
// events are accepted while one is being divided or a result waits.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the
// user must write it only while the block is idle; this is not enforced.
// Code list writes fill entries at a wrapping pointer. Synchronous reset
// restores the control state and clears the remainder. When m_axis_tready
// stays low the result is held, the queue fills and s_axis_tready drops.
module scroll_scaler_remainder_carry_core #(
    parameter int P_MAX_CODES     = ssrc_pkg::MAX_CODES_DEF,
    parameter int P_SPEED_DEFAULT = ssrc_pkg::SPEED_DEFAULT_DEF,
    parameter int P_SPEED_MIN     = ssrc_pkg::SPEED_MIN_DEF,
    parameter int P_SPEED_MAX     = ssrc_pkg::SPEED_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // event_type [7:0], event_code [23:8], event_value [55:24]
    input  logic [ssrc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_value [31:0]
    output logic [ssrc_pkg::VALUE_W-1:0]     m_axis_tdata,
    // was_scaled [0]
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssrc_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int DVD_W = ssrc_pkg::DVS_W + $clog2(P_SPEED_DEFAULT + 1);
    localparam int WP_W  = (P_MAX_CODES > 1) ? $clog2(P_MAX_CODES) : 1;
    localparam int DW    = ssrc_pkg::DVS_W;

    logic [ssrc_pkg::TYPE_W-1:0]             r_match_type;
    logic [P_MAX_CODES-1:0][ssrc_pkg::CODE_W-1:0] r_codes;
    logic [WP_W-1:0]                         r_wptr;
    logic [ssrc_pkg::CNT_USE_W-1:0]          r_codes_use;
    logic [ssrc_pkg::NARROW_W-1:0]           r_mult;
    logic [DW-1:0]                           r_base;
    logic [DW-1:0]                           r_speed;
    logic                                    r_carry_en;
    logic [DW-1:0]                           w_speed_clamped;

    ssrc_pkg::t_front_cfg w_front_cfg;
    ssrc_pkg::t_back_cfg  w_back_cfg;
    ssrc_pkg::t_item      w_push_item;
    ssrc_pkg::t_item      w_head;
    logic                 w_push;
    logic                 w_full;
    logic                 w_q_valid;
    logic                 w_pop;

    always_comb begin
        if (i_cfg_data < DW'(P_SPEED_MIN)) begin
            w_speed_clamped = DW'(P_SPEED_MIN);
        end else if (i_cfg_data > DW'(P_SPEED_MAX)) begin
            w_speed_clamped = DW'(P_SPEED_MAX);
        end else begin
            w_speed_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_type <= ssrc_pkg::MATCH_TYPE_RST;
            r_codes      <= '0;
            r_wptr       <= '0;
            r_codes_use  <= ssrc_pkg::CODES_USE_RST;
            r_mult       <= ssrc_pkg::MULT_RST;
            r_base       <= ssrc_pkg::BASE_DIV_RST;
            r_speed      <= DW'(P_SPEED_DEFAULT);
            r_carry_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssrc_pkg::CFG_MATCH_TYPE: r_match_type <= i_cfg_data[ssrc_pkg::TYPE_W-1:0];
                ssrc_pkg::CFG_CODE_LIST: begin
                    r_codes[r_wptr] <= i_cfg_data;
                    r_wptr <= (r_wptr == WP_W'(P_MAX_CODES - 1)) ? '0 : r_wptr + 1'b1;
                end
                ssrc_pkg::CFG_CODES_USE:  r_codes_use <= i_cfg_data[ssrc_pkg::CNT_USE_W-1:0];
                ssrc_pkg::CFG_MULTIPLIER: r_mult      <= i_cfg_data;
                ssrc_pkg::CFG_BASE_DIV:   r_base      <= i_cfg_data;
                ssrc_pkg::CFG_SPEED:      r_speed     <= w_speed_clamped;
                ssrc_pkg::CFG_CARRY_EN:   r_carry_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_front_cfg.match_type   = r_match_type;
    assign w_front_cfg.codes_in_use = r_codes_use;
    assign w_front_cfg.multiplier   = r_mult;
    assign w_back_cfg.base_divisor  = r_base;
    assign w_back_cfg.speed_percent = r_speed;
    assign w_back_cfg.carry_en      = r_carry_en;

    ssrc_front #(
        .P_MAX_CODES (P_MAX_CODES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_cfg    (w_front_cfg),
        .i_codes  (r_codes),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    ssrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    ssrc_back #(
        .P_DVD_W         (DVD_W),
        .P_SPEED_DEFAULT (P_SPEED_DEFAULT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_back_cfg),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_head),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (m_axis_tdata),
        .o_scaled  (m_axis_tuser)
    );

endmodule
